[rtl/h264_length_prefix_to_start_code_macros.svh]
// Assertion macros shared by the conversion block
`ifndef H264_LENGTH_PREFIX_TO_START_CODE_MACROS_SVH
`define H264_LENGTH_PREFIX_TO_START_CODE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define H264LPSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication
`define H264LPSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define H264LPSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define H264LPSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/h264lpsc_pkg.sv]
`timescale 1ns / 1ps

package h264lpsc_pkg;

    localparam int FRAME_W   = 24;   // frame size and position width
    localparam int ACC_W     = 32;   // length accumulator width
    localparam int APB_DW    = 32;
    localparam int PADDR_W   = 3;
    localparam int LEN_SZ_W  = 3;

    localparam logic [LEN_SZ_W-1:0] NAL_LEN_SIZE_RST = 3'd4;
    localparam logic [PADDR_W-3:0]  REG_NAL_LEN_SIZE = 1'b0;

    localparam logic [4:0] NAL_TYPE_NON_IDR = 5'd1;
    localparam logic [4:0] NAL_TYPE_IDR     = 5'd5;

    typedef enum logic [1:0] {
        PH_LEN   = 2'd0,
        PH_PAY   = 2'd1,
        PH_TRAIL = 2'd2
    } t_phase;

    // one entry to the output serialiser: a single byte, a 4-byte start code, or an end-of-frame status with no byte
    typedef struct packed {
        logic       four;
        logic [7:0] data;
        logic       bv;
        logic       fe;
        logic       key;
        logic       trunc;
    } t_bundle;

    // register values outside 1..4 saturate
    function automatic logic [LEN_SZ_W-1:0] eff_len(input logic [LEN_SZ_W-1:0] v);
        logic [LEN_SZ_W-1:0] r;
        case (v)
            3'd0: begin
                r = 3'd1;
            end
            3'd1, 3'd2, 3'd3, 3'd4: begin
                r = v;
            end
            default: begin
                r = 3'd4;
            end
        endcase
        return r;
    endfunction

endpackage

[rtl/h264lpsc_in_if.sv]
`timescale 1ns / 1ps

interface h264lpsc_in_if;
    logic                             valid;
    logic                             ready;
    logic [7:0]                       data_byte;
    logic [h264lpsc_pkg::FRAME_W-1:0] frame_size;

    modport source (output valid, output data_byte, output frame_size, input ready);
    modport sink   (input valid, input data_byte, input frame_size, output ready);
endinterface

[rtl/h264lpsc_out_if.sv]
`timescale 1ns / 1ps

interface h264lpsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       frame_end;
    logic       key_frame;
    logic       truncated;

    modport source (output valid, output out_byte, output byte_valid, output run_last,
                    output frame_end, output key_frame, output truncated, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                    input frame_end, input key_frame, input truncated, output ready);
endinterface

[rtl/h264lpsc_parse.sv]
`timescale 1ns / 1ps
`include "h264_length_prefix_to_start_code_macros.svh"

module h264lpsc_parse (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [h264lpsc_pkg::LEN_SZ_W-1:0]   i_len_size,
    h264lpsc_in_if.sink                         i_in,
    input  logic                                i_bnd_free,
    output logic                                o_bnd_load,
    output h264lpsc_pkg::t_bundle               o_bnd
);

    localparam int FW = h264lpsc_pkg::FRAME_W;
    localparam int AW = h264lpsc_pkg::ACC_W;

    // input register
    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic [FW-1:0] r_in_fs;

    // per-frame state
    logic [FW-1:0]         r_pos,      n_pos;
    h264lpsc_pkg::t_phase  r_phase,    n_phase;
    logic [1:0]            r_len_idx,  n_len_idx;
    logic [AW-1:0]         r_accum,    n_accum;
    logic [FW-1:0]         r_pay_left, n_pay_left;
    logic [4:0]            r_ltype,    n_ltype;
    logic                  r_trunc,    n_trunc;
    logic                  r_pend,     n_pend;

    logic [h264lpsc_pkg::LEN_SZ_W-1:0] w_len;
    logic [FW:0]           w_p1;
    logic [FW:0]           w_pl_sum;
    logic [FW:0]           w_diff;
    logic [FW-1:0]         w_left;
    logic [AW-1:0]         w_accum_n;
    logic                  w_last;
    logic                  w_starts;
    logic                  w_final;
    logic                  w_over;
    logic                  w_wide;
    h264lpsc_pkg::t_phase  w_ph;
    logic                  w_emit_len;
    logic                  w_four;
    logic                  w_pass;
    logic                  w_has;
    logic                  w_produce;
    logic                  w_move;
    logic                  w_accept;

    h264lpsc_pkg::t_phase  upd_phase;
    logic [1:0]            upd_len_idx;
    logic [AW-1:0]         upd_accum;
    logic [FW-1:0]         upd_pay_left;
    logic [FW-1:0]         upd_pay_dec;
    logic [4:0]            upd_ltype;
    logic                  upd_trunc;
    logic                  upd_pend;

    assign w_len      = h264lpsc_pkg::eff_len(i_len_size);
    assign w_wide     = (w_len >= 3'd3);
    assign w_p1       = {1'b0, r_pos} + (FW+1)'(1);
    assign w_last     = (w_p1 >= {1'b0, r_in_fs});
    assign w_pl_sum   = {1'b0, r_pos} + {{(FW-2){1'b0}}, w_len};
    assign w_starts   = (w_pl_sum < {1'b0, r_in_fs});
    assign w_diff     = {1'b0, r_in_fs} - w_p1;
    assign w_left     = w_last ? '0 : w_diff[FW-1:0];
    assign w_accum_n  = {r_accum[AW-9:0], r_in_byte};
    assign w_final    = (({1'b0, r_len_idx} + 3'd1) >= w_len);
    assign w_over     = (w_accum_n > {{(AW-FW){1'b0}}, w_left});

    // past the last full length field, the rest of the frame is trailing
    assign w_ph = (r_phase == h264lpsc_pkg::PH_LEN && r_len_idx == 2'd0 && !w_starts)
                  ? h264lpsc_pkg::PH_TRAIL : r_phase;

    assign w_emit_len = (w_ph == h264lpsc_pkg::PH_LEN) && w_wide;
    assign w_four     = (w_ph == h264lpsc_pkg::PH_LEN) && w_final && !w_wide;
    assign w_pass     = (w_ph == h264lpsc_pkg::PH_PAY) ||
                        (w_ph == h264lpsc_pkg::PH_TRAIL && w_wide);
    assign w_has      = w_emit_len || w_four || w_pass;
    assign w_produce  = w_has || w_last;

    // items that give no result never wait for the serialiser
    assign w_move     = r_in_valid && (!w_produce || i_bnd_free);
    assign i_in.ready = !r_in_valid || w_move;
    assign w_accept   = i_in.valid && i_in.ready;
    assign o_bnd_load = w_move && w_produce;

    assign upd_pay_dec = (r_pay_left != '0) ? (r_pay_left - FW'(1)) : '0;

    // state after this byte, before end-of-frame clearing
    always_comb begin
        upd_phase    = w_ph;
        upd_len_idx  = r_len_idx;
        upd_accum    = r_accum;
        upd_pay_left = r_pay_left;
        upd_trunc    = r_trunc;
        upd_pend     = 1'b0;
        upd_ltype    = r_ltype;
        if (r_pend && r_ltype != h264lpsc_pkg::NAL_TYPE_NON_IDR &&
            r_ltype != h264lpsc_pkg::NAL_TYPE_IDR) begin
            upd_ltype = r_in_byte[4:0];
        end
        case (w_ph)
            h264lpsc_pkg::PH_LEN: begin
                if (w_final) begin
                    upd_len_idx = 2'd0;
                    upd_accum   = '0;
                    upd_pend    = 1'b1;
                    if (w_over) begin
                        upd_pay_left = w_left;
                        upd_trunc    = 1'b1;
                        upd_ltype    = h264lpsc_pkg::NAL_TYPE_NON_IDR;
                    end else begin
                        upd_pay_left = w_accum_n[FW-1:0];
                    end
                    upd_phase = (upd_pay_left != '0) ? h264lpsc_pkg::PH_PAY
                                                     : h264lpsc_pkg::PH_LEN;
                end else begin
                    upd_accum   = w_accum_n;
                    upd_len_idx = r_len_idx + 2'd1;
                end
            end
            h264lpsc_pkg::PH_PAY: begin
                upd_pay_left = upd_pay_dec;
                if (upd_pay_dec == '0) begin
                    upd_phase = h264lpsc_pkg::PH_LEN;
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_pos      = r_pos;
        n_phase    = r_phase;
        n_len_idx  = r_len_idx;
        n_accum    = r_accum;
        n_pay_left = r_pay_left;
        n_ltype    = r_ltype;
        n_trunc    = r_trunc;
        n_pend     = r_pend;
        if (w_move) begin
            if (w_last) begin
                n_pos      = '0;
                n_phase    = h264lpsc_pkg::PH_LEN;
                n_len_idx  = 2'd0;
                n_accum    = '0;
                n_pay_left = '0;
                n_ltype    = '0;
                n_trunc    = 1'b0;
                n_pend     = 1'b0;
            end else begin
                n_pos      = w_p1[FW-1:0];
                n_phase    = upd_phase;
                n_len_idx  = upd_len_idx;
                n_accum    = upd_accum;
                n_pay_left = upd_pay_left;
                n_ltype    = upd_ltype;
                n_trunc    = upd_trunc;
                n_pend     = upd_pend;
            end
        end
    end

    // result bundle
    always_comb begin
        o_bnd.four  = w_four;
        o_bnd.bv    = w_has;
        o_bnd.fe    = w_last;
        o_bnd.key   = w_last && (upd_ltype == h264lpsc_pkg::NAL_TYPE_IDR);
        o_bnd.trunc = w_last && upd_trunc;
        if (w_emit_len) begin
            o_bnd.data = {7'd0, w_final};
        end else if (w_pass) begin
            o_bnd.data = r_in_byte;
        end else begin
            o_bnd.data = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pos      <= '0;
            r_phase    <= h264lpsc_pkg::PH_LEN;
            r_len_idx  <= 2'd0;
            r_accum    <= '0;
            r_pay_left <= '0;
            r_ltype    <= '0;
            r_trunc    <= 1'b0;
            r_pend     <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_move) begin
                r_in_valid <= 1'b0;
            end
            r_pos      <= n_pos;
            r_phase    <= n_phase;
            r_len_idx  <= n_len_idx;
            r_accum    <= n_accum;
            r_pay_left <= n_pay_left;
            r_ltype    <= n_ltype;
            r_trunc    <= n_trunc;
            r_pend     <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_in.data_byte;
            r_in_fs   <= i_in.frame_size;
        end
    end

    `H264LPSC_ASSERT_IMP(a_pay_nonzero, i_clk, i_rst_n, r_phase == h264lpsc_pkg::PH_PAY,
        r_pay_left != '0)
    `H264LPSC_ASSERT_NXT(a_frame_clear, i_clk, i_rst_n, w_move && w_last,
        r_pos == '0 && r_phase == h264lpsc_pkg::PH_LEN && !r_pend)

endmodule

[rtl/h264lpsc_emit.sv]
`timescale 1ns / 1ps
`include "h264_length_prefix_to_start_code_macros.svh"

module h264lpsc_emit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_bnd_load,
    input  h264lpsc_pkg::t_bundle   i_bnd,
    output logic                    o_bnd_free,
    h264lpsc_out_if.source          o_out
);

    logic                  r_valid;
    h264lpsc_pkg::t_bundle r_bnd;
    logic [1:0]            r_idx;
    logic                  w_lastidx;
    logic                  w_take;

    // a start code runs over four requests, anything else is one
    assign w_lastidx  = !r_bnd.four || (r_idx == 2'd3);
    assign w_take     = r_valid && o_out.ready;
    assign o_bnd_free = !r_valid || (o_out.ready && w_lastidx);

    assign o_out.valid      = r_valid;
    assign o_out.out_byte   = r_bnd.four ? {7'd0, (r_idx == 2'd3)} : r_bnd.data;
    assign o_out.byte_valid = r_bnd.bv;
    assign o_out.run_last   = w_lastidx;
    assign o_out.frame_end  = r_bnd.fe && w_lastidx;
    assign o_out.key_frame  = r_bnd.key && w_lastidx;
    assign o_out.truncated  = r_bnd.trunc && w_lastidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (i_bnd_load) begin
                r_valid <= 1'b1;
                r_idx   <= 2'd0;
            end else if (w_take) begin
                if (w_lastidx) begin
                    r_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bnd_load) begin
            r_bnd <= i_bnd;
        end
    end

    `H264LPSC_ASSERT_IMP(a_idx_single, i_clk, i_rst_n, r_valid && !r_bnd.four, r_idx == 2'd0)
    `H264LPSC_ASSERT_IMP(a_status_only, i_clk, i_rst_n, o_out.valid && !o_out.byte_valid,
        o_out.frame_end && o_out.run_last && o_out.out_byte == 8'd0)

endmodule

[rtl/h264_length_prefix_to_start_code.sv]
`timescale 1ns / 1ps
// Each byte is held in the input register, then its result in the serialiser's bundle register.
// Throughput: one input byte per cycle while the output is ready and each byte gives at most
//   one result; a 00 00 00 01 start code insertion holds back input until all four bytes are taken.
// The output serialiser (one bundle of up to four results) sets the rate.
// Reset (synchronous, active low) clears all frame state and sets the
//   length size to 4; no clearing pass is needed.

module h264_length_prefix_to_start_code (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    h264lpsc_in_if.sink                          i_in,
    h264lpsc_out_if.source                       o_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [h264lpsc_pkg::PADDR_W-1:0]     paddr,
    input  logic [h264lpsc_pkg::APB_DW-1:0]      pwdata,
    output logic [h264lpsc_pkg::APB_DW-1:0]      prdata,
    output logic                                 pready
);

    logic [h264lpsc_pkg::LEN_SZ_W-1:0] r_len_size;
    logic                              w_sel_len;
    logic                              w_bnd_free;
    logic                              w_bnd_load;
    h264lpsc_pkg::t_bundle             w_bnd;

    assign pready    = 1'b1;
    assign w_sel_len = (paddr[h264lpsc_pkg::PADDR_W-1:2] == h264lpsc_pkg::REG_NAL_LEN_SIZE);
    assign prdata    = w_sel_len
                       ? {{(h264lpsc_pkg::APB_DW-h264lpsc_pkg::LEN_SZ_W){1'b0}}, r_len_size}
                       : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_size <= h264lpsc_pkg::NAL_LEN_SIZE_RST;
        end else if (psel && penable && pwrite && w_sel_len) begin
            r_len_size <= pwdata[h264lpsc_pkg::LEN_SZ_W-1:0];
        end
    end

    h264lpsc_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_len_size (r_len_size),
        .i_in       (i_in),
        .i_bnd_free (w_bnd_free),
        .o_bnd_load (w_bnd_load),
        .o_bnd      (w_bnd)
    );

    h264lpsc_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bnd_load (w_bnd_load),
        .i_bnd      (w_bnd),
        .o_bnd_free (w_bnd_free),
        .o_out      (o_out)
    );

endmodule
